>>> sv/xorshift128_ranged_generator_defines.svh
// Assertion macros shared by the xorshift128 ranged generator RTL.
`ifndef XORSHIFT128_RANGED_GENERATOR_DEFINES_SVH
`define XORSHIFT128_RANGED_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define XRG_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("xrg check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define XRG_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("xrg check failed");

`endif

>>> sv/xrg_pkg.sv
// Package with the types, constants and functions of the xorshift128 ranged generator.
`default_nettype none

package xrg_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam int ADDR_W = 3;

    localparam logic [WORD_W-1:0] SEED_X = 32'd123456789;
    localparam logic [WORD_W-1:0] SEED_Y = 32'd362436069;
    localparam logic [WORD_W-1:0] SEED_Z = 32'd521288629;
    localparam logic [WORD_W-1:0] SEED_W = 32'd88675123;

    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 19;
    localparam int SHIFT_C = 8;

    localparam logic [WORD_W-1:0] OFFSET_RESET  = 32'd0;
    localparam logic [WORD_W-1:0] MODULUS_RESET = 32'hFFFF_FFFF;

    localparam logic [ADDR_W-1:0] ADDR_OFFSET  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // One xorshift128 step: the new w from the old x and the old w.
    function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] x,
                                                     input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = x ^ (x << SHIFT_A);
        return (w ^ (w >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
    endfunction

endpackage

`default_nettype wire

>>> sv/xorshift128_ranged_generator.sv
// Top level of the xorshift128 generator with a ranged (offset plus modulo) output.
// An accepted draw beat of value one advances the generator and starts the serial remainder
// unit; its done flag moves the sequencer on to the result beat, which is held until taken.
// The draw channel stalls from acceptance until the result beat has been taken.
// Reset (rst_n low, asynchronous) loads the published seeds, offset 0, modulus all ones.
`default_nettype none
`include "xorshift128_ranged_generator_defines.svh"

module xorshift128_ranged_generator
    import xrg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready,
    // Draw request channel.
    input  wire logic              draw_valid,
    output logic                   draw_stall,
    input  wire logic              draw,
    // Result channel.
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic      [WORD_W-1:0] random_word,
    output logic      [WORD_W-1:0] ranged_value
);

    // Sequencer state.
    state_t state_reg, state_next;

    // Generator state words.
    logic [WORD_W-1:0] word_x_reg, word_y_reg, word_z_reg, word_w_reg;
    logic [WORD_W-1:0] word_w_next;

    // Configuration registers.
    logic [WORD_W-1:0] range_offset_reg, range_modulus_reg;

    logic              draw_accept;
    logic              result_accept;
    logic              cfg_write;
    logic [WORD_W-1:0] range_sum;

    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;
    logic [WORD_W-1:0] div_rem;

    assign draw_accept   = draw_valid && !draw_stall;
    assign result_accept = result_valid && !result_stall;
    assign cfg_write     = psel && penable && pwrite && pready;

    // The register port never waits.
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_OFFSET:  prdata = range_offset_reg;
            ADDR_MODULUS: prdata = range_modulus_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_offset_reg  <= OFFSET_RESET;
            range_modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_OFFSET:  range_offset_reg  <= pwdata;
                ADDR_MODULUS: range_modulus_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    // The state advance is combinational shifts and XORs. The new word is
    // added to the offset in the same cycle and the wrapped 32-bit sum goes
    // straight into the remainder unit as its dividend.
    assign word_w_next = xs_advance(word_x_reg, word_w_reg);
    assign range_sum   = range_offset_reg + word_w_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_x_reg <= SEED_X;
            word_y_reg <= SEED_Y;
            word_z_reg <= SEED_Z;
            word_w_reg <= SEED_W;
        end
        else if (div_ctrl.start)
        begin
            word_x_reg <= word_y_reg;
            word_y_reg <= word_z_reg;
            word_z_reg <= word_w_reg;
            word_w_reg <= word_w_next;
        end
    end

    // Next-state logic. A draw beat whose value is zero is taken and dropped:
    // the generator does not move and no result beat follows.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (draw_accept && draw)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        draw_stall     = 1'b1;
        result_valid   = 1'b0;
        div_ctrl.start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                draw_stall     = 1'b0;
                div_ctrl.start = draw_valid && draw;
            end
            ST_DIV:
            begin
                draw_stall = 1'b1;
            end
            ST_OUT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                draw_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Serial remainder: the wrapped sum modulo the configured modulus. A zero
    // modulus returns the sum itself.
    xrg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (range_sum),
        .divisor   (range_modulus_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // Both result fields hold steady from the end of the reduction until the
    // beat is taken, since nothing new starts before then.
    assign random_word  = word_w_reg;
    assign ranged_value = div_rem;

    `XRG_ASSERT_IMP(a_done_in_div, div_stat.done, state_reg == ST_DIV)
    `XRG_ASSERT_IMP(a_div_working, state_reg == ST_DIV, div_stat.busy || div_stat.done)
    `XRG_ASSERT_NXT(a_back_to_idle, result_accept, state_reg == ST_IDLE)
    `XRG_ASSERT_NXT(a_words_shift, draw_accept && draw, word_x_reg == $past(word_y_reg))

endmodule

`default_nettype wire

>>> sv/xrg_divider.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module xrg_divider
    import xrg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_ctrl_t         ctrl,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [WORD_W-1:0] divisor,
    output div_stat_t              stat,
    output logic      [WORD_W-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W-1:0] rem_reg, rem_next;

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              fits;

    // A zero divisor always fits, so the remainder collects the dividend unchanged.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[WORD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            dvd_next   = dividend;
            dvs_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            dvd_next   = dvd_reg << 1;
            rem_next   = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
